FILE: design/jesc_pkg.sv
package jesc_pkg;

    // image and iteration limits
    localparam int IMG_WIDTH  = 1024;
    localparam int IMG_HEIGHT = 1024;
    localparam int ITER_LIMIT = 256;

    // field widths
    localparam int Q_W      = 32;
    localparam int FRAC_W   = 28;
    localparam int PIX_W    = 10;
    localparam int ZOOM_W   = 31;
    localparam int RAD_W    = 3;
    localparam int CNT_OUT_W = 8;
    localparam int PROD_W   = 2 * Q_W;

    // stream and config port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // iteration counter holds the limit itself
    localparam int CNT_W = $clog2(ITER_LIMIT + 1);

    // pixel mapping: numerator p * 2 * zoom divided by size - 1
    localparam int SIZE_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
    localparam int DIV_W    = $clog2(SIZE_MAX);
    localparam int NUM_W    = PIX_W + ZOOM_W + 1;
    localparam int SUM_W    = NUM_W + 2;

    // reciprocal floor(2^RCP_K / divisor), applied in two halves of the numerator
    localparam int RCP_K  = NUM_W;
    localparam int RCP_W  = RCP_K + 1;
    localparam int HALF_W = (NUM_W + 1) / 2;
    localparam int PP_W   = HALF_W + RCP_W;
    localparam int ACC_W  = NUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_X = RCP_W'((64'd1 << RCP_K) / 64'(IMG_WIDTH - 1));
    localparam logic [RCP_W-1:0] RCP_Y = RCP_W'((64'd1 << RCP_K) / 64'(IMG_HEIGHT - 1));

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL      = 3'd0,
        CFG_C_IMAG      = 3'd1,
        CFG_RADIUS      = 3'd2,
        CFG_ZOOM        = 3'd3,
        CFG_CENTRE_REAL = 3'd4,
        CFG_CENTRE_IMAG = 3'd5
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_UPD,
        ST_HOLD
    } state_t;

    // start-point mapping steps
    typedef enum logic [2:0] {
        MS_IDLE,
        MS_LO,
        MS_HI,
        MS_FIX,
        MS_SUM
    } map_state_t;

    // controls for the iteration unit
    typedef struct packed {
        logic load;
        logic mul_en;
        logic upd_en;
    } iter_ctrl_t;

    // clamp a wide signed value to q4.28 limits
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
        lo = {{(PROD_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
        if (v > hi) begin
            sat_q = hi[Q_W-1:0];
        end else if (v < lo) begin
            sat_q = lo[Q_W-1:0];
        end else begin
            sat_q = v[Q_W-1:0];
        end
    endfunction

    // reported count: zero at the limit, clamped to the field
    function automatic logic [CNT_OUT_W-1:0] esc_count(input logic [CNT_W-1:0] cnt);
        if (cnt == CNT_W'(ITER_LIMIT)) begin
            esc_count = '0;
        end else if (32'(cnt) > 32'd255) begin
            esc_count = {CNT_OUT_W{1'b1}};
        end else begin
            esc_count = CNT_OUT_W'(cnt);
        end
    endfunction

endpackage

FILE: design/julia_escape_time_pixel.sv
// julia set escape-time engine, one pixel per input beat
//
// s_ channel: a pixel coordinate beat; m_ channel: the coordinate echoed with
// its escape count. cfg_ channel writes the julia constant, escape radius,
// zoom half span and view centre; cfg_ready is always high, and the user
// must make writes while no pixel is in flight; the block does not enforce it.
//
// the start-point mapping is a reciprocal multiply in two halves, a one-step
// correction and the offset; each escape iteration is a product step for the
// three products followed by a test-and-update step, and iterating stops at
// escape or at the iteration limit. one pixel is worked on at a time:
// s_tready is high only while the engine is idle, so the next pixel is taken
// only once the previous one has left the engine.
//
// a finished result sits in the output register until m_tready; the next
// pixel is accepted meanwhile, and if it finishes before the previous beat
// is taken it waits in the engine. reset clears the engine, drops m_tvalid
// and loads the register defaults (radius 2, half span 2.0, others zero).
module julia_escape_time_pixel (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jesc_pkg::S_TDATA_W-1:0]      s_tdata,   // pixel_x, pixel_y
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [jesc_pkg::M_TDATA_W-1:0]      m_tdata,   // out_x, out_y, escape_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jesc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jesc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jesc_pkg::*;

    state_t                  state_reg, state_next;
    logic [PIX_W-1:0]        px_reg, py_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [Q_W-1:0]   c_real_reg, c_imag_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic [ZOOM_W-1:0]       zoom_reg;
    logic signed [Q_W-1:0]   centre_real_reg, centre_imag_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic                    map_start;
    logic                    map_done_x, map_done_y, map_done;
    logic signed [Q_W-1:0]   zx0, zy0;
    iter_ctrl_t              ictl;
    logic                    escape;
    logic                    finish;
    logic                    out_free;
    logic                    out_wr;
    logic                    s_accept;

    assign s_accept  = s_tvalid && s_tready;
    assign map_done  = map_done_x && map_done_y;
    assign finish    = escape || (cnt_reg >= CNT_W'(ITER_LIMIT));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // start point per axis, taken straight from the accepted beat
    jesc_map u_map_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (map_start),
        .pix     (s_tdata[PIX_W-1:0]),
        .divisor (DIV_W'(IMG_WIDTH - 1)),
        .recip   (RCP_X),
        .zoom    (zoom_reg),
        .centre  (centre_real_reg),
        .done    (map_done_x),
        .z       (zx0)
    );

    jesc_map u_map_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (map_start),
        .pix     (s_tdata[2*PIX_W-1:PIX_W]),
        .divisor (DIV_W'(IMG_HEIGHT - 1)),
        .recip   (RCP_Y),
        .zoom    (zoom_reg),
        .centre  (centre_imag_reg),
        .done    (map_done_y),
        .z       (zy0)
    );

    // shared escape iteration unit
    jesc_iter u_iter (
        .aclk    (aclk),
        .ctl     (ictl),
        .zx_init (zx0),
        .zy_init (zy0),
        .c_real  (c_real_reg),
        .c_imag  (c_imag_reg),
        .radius  (radius_reg),
        .escape  (escape)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                if (map_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (finish) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        map_start = 1'b0;
        ictl      = '0;
        out_wr    = 1'b0;
        cnt_next  = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                map_start = s_tvalid;
            end
            ST_MAP: begin
                if (map_done) begin
                    ictl.load = 1'b1;
                    cnt_next  = '0;
                end
            end
            ST_MUL: begin
                ictl.mul_en = 1'b1;
            end
            ST_UPD: begin
                if (finish) begin
                    out_wr = out_free;
                end else begin
                    ictl.upd_en = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
            end
            ST_HOLD: begin
                out_wr = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // output valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_wr) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // pixel capture, iteration count, result beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg <= s_tdata[PIX_W-1:0];
            py_reg <= s_tdata[2*PIX_W-1:PIX_W];
        end
        cnt_reg <= cnt_next;
        if (out_wr) begin
            m_tdata_reg <= {{(M_TDATA_W-2*PIX_W-CNT_OUT_W){1'b0}},
                            esc_count(cnt_reg), py_reg, px_reg};
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_real_reg      <= '0;
            c_imag_reg      <= '0;
            radius_reg      <= RAD_W'(2);
            zoom_reg        <= ZOOM_W'(536870912);
            centre_real_reg <= '0;
            centre_imag_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_C_REAL:      c_real_reg      <= cfg_data;
                CFG_C_IMAG:      c_imag_reg      <= cfg_data;
                CFG_RADIUS:      radius_reg      <= cfg_data[RAD_W-1:0];
                CFG_ZOOM:        zoom_reg        <= cfg_data[ZOOM_W-1:0];
                CFG_CENTRE_REAL: centre_real_reg <= cfg_data;
                CFG_CENTRE_IMAG: centre_imag_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: design/jesc_map.sv
module jesc_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [jesc_pkg::PIX_W-1:0]        pix,
    input  logic [jesc_pkg::DIV_W-1:0]        divisor,
    input  logic [jesc_pkg::RCP_W-1:0]        recip,
    input  logic [jesc_pkg::ZOOM_W-1:0]       zoom,
    input  logic signed [jesc_pkg::Q_W-1:0]   centre,
    output logic                              done,
    output logic signed [jesc_pkg::Q_W-1:0]   z
);
    import jesc_pkg::*;

    map_state_t               state_reg, state_next;
    logic                     done_reg, done_next;
    logic                     acc_lo, acc_hi, fix_q, set_z;
    logic [NUM_W-1:0]         x_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [NUM_W-1:0]         quot_reg;
    logic signed [Q_W-1:0]    z_reg;
    logic [NUM_W-1:0]         prod;
    logic [HALF_W-1:0]        mul_a;
    logic [PP_W-1:0]          mul_p;
    logic [NUM_W-1:0]         q_est;
    logic [DIV_W:0]           q_d_lo;
    logic [DIV_W:0]           rem;
    logic signed [SUM_W-1:0]  sum;

    // numerator p * 2 * zoom, exact
    assign prod = NUM_W'(pix) * NUM_W'({zoom, 1'b0});

    // one reciprocal multiplier, low half of the numerator first
    assign mul_a = acc_hi ? HALF_W'(x_reg[NUM_W-1:HALF_W]) : x_reg[HALF_W-1:0];
    assign mul_p = PP_W'(mul_a) * PP_W'(recip);

    // estimate is the quotient or one below; the low bits of the remainder settle it
    assign q_est  = acc_reg[RCP_K+NUM_W-1:RCP_K];
    assign q_d_lo = q_est[DIV_W:0] * {1'b0, divisor};
    assign rem    = x_reg[DIV_W:0] - q_d_lo;

    // quotient - zoom + centre, before clamping
    assign sum = $signed({2'b00, quot_reg})
               - $signed({{(SUM_W-ZOOM_W){1'b0}}, zoom})
               + $signed({{(SUM_W-Q_W){centre[Q_W-1]}}, centre});

    // next step
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MS_IDLE: begin
                if (start) begin
                    state_next = MS_LO;
                end
            end
            MS_LO: begin
                state_next = MS_HI;
            end
            MS_HI: begin
                state_next = MS_FIX;
            end
            MS_FIX: begin
                state_next = MS_SUM;
            end
            MS_SUM: begin
                state_next = MS_IDLE;
            end
            default: begin
                state_next = MS_IDLE;
            end
        endcase
    end

    // step controls
    always_comb begin
        acc_lo = 1'b0;
        acc_hi = 1'b0;
        fix_q  = 1'b0;
        set_z  = 1'b0;
        case (state_reg)
            MS_LO: begin
                acc_lo = 1'b1;
            end
            MS_HI: begin
                acc_hi = 1'b1;
            end
            MS_FIX: begin
                fix_q = 1'b1;
            end
            MS_SUM: begin
                set_z = 1'b1;
            end
            default: begin
            end
        endcase
        done_next = set_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // numerator, product sum, quotient and start point
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= prod;
        end
        if (acc_lo) begin
            acc_reg <= ACC_W'(mul_p);
        end else if (acc_hi) begin
            acc_reg <= acc_reg + (ACC_W'(mul_p) << HALF_W);
        end
        if (fix_q) begin
            quot_reg <= q_est + NUM_W'(rem >= {1'b0, divisor});
        end
        if (set_z) begin
            z_reg <= sat_q({{(PROD_W-SUM_W){sum[SUM_W-1]}}, sum});
        end
    end

    assign done = done_reg;
    assign z    = z_reg;

endmodule

FILE: design/jesc_iter.sv
module jesc_iter (
    input  logic                              aclk,
    input  jesc_pkg::iter_ctrl_t              ctl,
    input  logic signed [jesc_pkg::Q_W-1:0]   zx_init,
    input  logic signed [jesc_pkg::Q_W-1:0]   zy_init,
    input  logic signed [jesc_pkg::Q_W-1:0]   c_real,
    input  logic signed [jesc_pkg::Q_W-1:0]   c_imag,
    input  logic [jesc_pkg::RAD_W-1:0]        radius,
    output logic                              escape
);
    import jesc_pkg::*;

    logic signed [Q_W-1:0]     zx_reg, zx_next;
    logic signed [Q_W-1:0]     zy_reg, zy_next;
    logic signed [PROD_W-1:0]  sx_reg, sy_reg, sxy_reg;
    logic [PROD_W-1:0]         mag;
    logic [2*RAD_W-1:0]        r2;
    logic signed [PROD_W-1:0]  dx;
    logic signed [PROD_W-1:0]  nx, ny;

    // squared magnitude against r*r in q8.56
    assign mag    = $unsigned(sx_reg) + $unsigned(sy_reg);
    assign r2     = (2*RAD_W)'(radius) * (2*RAD_W)'(radius);
    assign escape = !(mag[PROD_W-1:PROD_W-8] < 8'(r2));

    // z*z + c, floored and clamped
    always_comb begin
        dx      = sx_reg - sy_reg;
        nx      = (dx >>> FRAC_W) + PROD_W'(c_real);
        ny      = (sxy_reg >>> (FRAC_W - 1)) + PROD_W'(c_imag);
        zx_next = sat_q(nx);
        zy_next = sat_q(ny);
    end

    // z registers
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            zx_reg <= zx_init;
            zy_reg <= zy_init;
        end else if (ctl.upd_en) begin
            zx_reg <= zx_next;
            zy_reg <= zy_next;
        end
    end

    // products of the current z
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            sx_reg  <= PROD_W'(zx_reg) * PROD_W'(zx_reg);
            sy_reg  <= PROD_W'(zy_reg) * PROD_W'(zy_reg);
            sxy_reg <= PROD_W'(zx_reg) * PROD_W'(zy_reg);
        end
    end

endmodule

FILE: design/jesc_chk.sv
module jesc_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [jesc_pkg::M_TDATA_W-1:0]      m_tdata
);
    import jesc_pkg::*;

    // a stalled result beat holds
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // engine is busy right after taking a pixel
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("pixel accepted while engine busy");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind julia_escape_time_pixel jesc_chk u_jesc_chk (.*);

FILE: tb/julia_escape_time_pixel_test.sv
`timescale 1ns / 100ps

module julia_escape_time_pixel_test;

    import jesc_pkg::*;

    // write indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // one in q4.28
    localparam int Q_ONE = 1 << FRAC_W;

    // expected output beat
    typedef struct {
        logic [PIX_W-1:0]     x;
        logic [PIX_W-1:0]     y;
        logic [CNT_OUT_W-1:0] count;
    } pixel_result_t;

    // escape-time predictor with its own register copy and pending results
    class julia_scoreboard;
        logic signed [Q_W-1:0] c_re;
        logic signed [Q_W-1:0] c_im;
        logic signed [Q_W-1:0] ctr_re;
        logic signed [Q_W-1:0] ctr_im;
        logic [RAD_W-1:0]      radius;
        logic [ZOOM_W-1:0]     half_span;
        pixel_result_t         pending[$];
        int                    errors;

        function new();
            c_re      = '0;
            c_im      = '0;
            ctr_re    = '0;
            ctr_im    = '0;
            radius    = 3'd2;
            half_span = 31'(2 * Q_ONE);
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_C_REAL: begin
                    c_re = val;
                end
                CFG_C_IMAG: begin
                    c_im = val;
                end
                CFG_RADIUS: begin
                    radius = val[RAD_W-1:0];
                end
                CFG_ZOOM: begin
                    half_span = val[ZOOM_W-1:0];
                end
                CFG_CENTRE_REAL: begin
                    ctr_re = val;
                end
                CFG_CENTRE_IMAG: begin
                    ctr_im = val;
                end
                default: begin
                end
            endcase
        endfunction

        // clamp to the q4.28 range
        function longint clamp_q(longint v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // pixel index to start coordinate on one axis
        function longint start_point(logic [PIX_W-1:0] p, int size, logic signed [Q_W-1:0] ctr);
            longint num;
            longint q;
            num = longint'(p) * 2 * longint'(half_span);
            q = num / (size - 1);
            return clamp_q(q - longint'(half_span) + longint'(ctr));
        endfunction

        function logic [CNT_OUT_W-1:0] escape_count_of(logic [PIX_W-1:0] px,
                                                       logic [PIX_W-1:0] py);
            longint      zx;
            longint      zy;
            longint      sx;
            longint      sy;
            longint      nx;
            longint      ny;
            logic [63:0] mag;
            logic [63:0] bound;
            int          n;
            zx = start_point(px, IMG_WIDTH, ctr_re);
            zy = start_point(py, IMG_HEIGHT, ctr_im);
            bound = (64'(radius) * 64'(radius)) << (2 * FRAC_W);
            // iterate z = z*z + c until escape or the limit
            for (n = 0; n < ITER_LIMIT; n++) begin
                sx = zx * zx;
                sy = zy * zy;
                mag = sx + sy;
                if (!(mag < bound)) begin
                    break;
                end
                nx = ((sx - sy) >>> FRAC_W) + longint'(c_re);
                ny = ((zx * zy) >>> (FRAC_W - 1)) + longint'(c_im);
                zx = clamp_q(nx);
                zy = clamp_q(ny);
            end
            if (n == ITER_LIMIT) begin
                return '0;
            end
            if (n > 255) begin
                return '1;
            end
            return CNT_OUT_W'(n);
        endfunction

        function void note_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
            pixel_result_t r;
            r.x = x;
            r.y = y;
            r.count = escape_count_of(x, y);
            pending.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            pixel_result_t r;
            logic [PIX_W-1:0]     got_x;
            logic [PIX_W-1:0]     got_y;
            logic [CNT_OUT_W-1:0] got_count;
            got_x = data[PIX_W-1:0];
            got_y = data[2*PIX_W-1:PIX_W];
            got_count = data[2*PIX_W+CNT_OUT_W-1:2*PIX_W];
            if (pending.size() == 0) begin
                $error("result beat with nothing pending: out_x %0d out_y %0d", got_x, got_y);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (got_x !== r.x) begin
                $error("out_x: expected %0d, got %0d", r.x, got_x);
                errors++;
            end
            if (got_y !== r.y) begin
                $error("out_y: expected %0d, got %0d", r.y, got_y);
                errors++;
            end
            if (got_count !== r.count) begin
                $error("escape_count: expected %0d, got %0d (pixel %0d,%0d)",
                       r.count, got_count, r.x, r.y);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    julia_scoreboard sb;
    bit              tx_calm;
    bit              rx_calm;

    julia_escape_time_pixel uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watch all three channels for beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.set_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                sb.note_pixel(s_tdata[PIX_W-1:0], s_tdata[2*PIX_W-1:PIX_W]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // result side: random stall before each beat, with calm stretches
    initial begin
        int stall;
        m_tready <= 1'b0;
        rx_calm = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                rx_calm = !rx_calm;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one pixel beat after a random gap; valid stays high for a back-to-back beat
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            tx_calm = !tx_calm;
        end
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-2*PIX_W){1'b0}}, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every pending result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [31:0] c_re, input logic [31:0] c_im,
                             input logic [31:0] rad, input logic [31:0] span,
                             input logic [31:0] ctr_re, input logic [31:0] ctr_im);
        wait_idle();
        write_reg(CFG_C_REAL, c_re);
        write_reg(CFG_C_IMAG, c_im);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_ZOOM, span);
        write_reg(CFG_CENTRE_REAL, ctr_re);
        write_reg(CFG_CENTRE_IMAG, ctr_im);
        cfg_valid <= 1'b0;
    endtask

    // signed q4.28 value in [-mag, mag]
    function automatic logic [31:0] near_zero(input int unsigned mag);
        return 32'(int'($urandom_range(0, 2 * mag)) - int'(mag));
    endfunction

    // mostly well-framed views around the set, sometimes raw register values
    task automatic random_setting();
        int unsigned kind;
        kind = $urandom_range(0, 3);
        if (kind == 3) begin
            configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            configure(near_zero(Q_ONE), near_zero(Q_ONE),
                      (kind == 2) ? 32'($urandom_range(0, 7)) : 32'd2,
                      32'($urandom_range(Q_ONE / 4, 2 * Q_ONE)),
                      near_zero(Q_ONE / 2), near_zero(Q_ONE / 2));
        end
    endtask

    initial begin
        int ph;
        int k;
        sb = new();
        tx_calm = 1'b0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: corners, centre and alternating bit patterns
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd511, 10'd512);
        send_pixel(10'd341, 10'd682);

        // classic dendrite-like constant, radius 2, half span 1.5
        configure(32'd76503368, 32'd2684355, 32'd2, 32'd402653184, 32'd0, 32'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd300, 10'd700);
        send_pixel(10'd700, 10'd300);

        // radius zero never lets a point in
        configure(32'd76503368, 32'd2684355, 32'd0, 32'd402653184, 32'd0, 32'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);

        // radius 7, widest span, extreme centre and constant: everything saturates
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd7, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd0);

        // zero span maps every pixel onto the centre
        configure(32'hF400_0000, 32'h0200_0000, 32'd4, 32'd0, 32'hF800_0000, 32'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);

        // writes to undecoded indexes change nothing
        wait_idle();
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        send_pixel(10'd100, 10'd900);

        // random views with random pixels
        for (ph = 0; ph < 10; ph++) begin
            random_setting();
            for (k = 0; k < 50; k++) begin
                if (k == 25 && ph % 3 == 0) begin
                    wait_idle();
                end
                send_pixel(10'($urandom), 10'($urandom));
            end
        end

        wait_idle();
        repeat (600) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("julia_escape_time_pixel test passed");
        end else begin
            $display("julia_escape_time_pixel test failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #50_000_000;
        $display("julia_escape_time_pixel test failed");
        $finish;
    end

endmodule
